// ----- hdl/mmp_pkg.sv -----
// Shared types, constants and modular helpers for the matrix power block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package mmp_pkg;

  localparam int unsigned VW = 30;
  localparam logic [VW-1:0] PRIME = 30'd1000000007;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef struct packed {
    logic          operation;
    logic [2:0]    entry_row;
    logic [2:0]    entry_col;
    logic [VW-1:0] entry_value;
    logic [31:0]   exponent;
  } mmp_in_t;

  typedef struct packed {
    logic [2:0]    out_row;
    logic [2:0]    out_col;
    logic [VW-1:0] out_value;
    logic          last;
  } mmp_out_t;

  // One product in flight along the cell chain.
  typedef struct packed {
    logic          v;
    logic          first;
    logic          last;
    logic [VW-1:0] r;
    logic [VW-1:0] a;
    logic [VW-1:0] b;
  } mmp_lane_t;

  // Sum of two residues, both below PRIME.
  function automatic logic [VW-1:0] mod_add(logic [VW-1:0] x, logic [VW-1:0] y);
    logic [VW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, PRIME}) begin
      s = s - {1'b0, PRIME};
    end
    return s[VW-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/mmp_cell.sv -----
// One step of the bit-serial modular multiplier: r = 2r + a*bit mod PRIME.
// Depends on mmp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mmp_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mmp_pkg::mmp_lane_t lane_i,
  output mmp_pkg::mmp_lane_t lane_o
);
  import mmp_pkg::*;

  mmp_lane_t     lane_d, lane_q;
  logic [VW-1:0] dbl;

  always_comb begin
    lane_d   = lane_i;
    dbl      = mod_add(lane_i.r, lane_i.r);
    lane_d.r = lane_i.b[VW-1] ? mod_add(dbl, lane_i.a) : dbl;
    lane_d.b = {lane_i.b[VW-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= '0;
    end else begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule
`default_nettype wire

// ----- hdl/mmp_mac.sv -----
// Modular multiply-accumulate: a chain of VW cells, one multiplier bit each,
// followed by the dot-product accumulator. Depends on mmp_pkg and mmp_cell.
`timescale 1ns / 1ps
`default_nettype none
module mmp_mac (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic                  first_i,
  input  logic                  last_i,
  input  logic [mmp_pkg::VW-1:0] x_i,
  input  logic [mmp_pkg::VW-1:0] y_i,
  output logic                  busy_o,
  output logic                  sum_valid_o,
  output logic [mmp_pkg::VW-1:0] sum_o
);
  import mmp_pkg::*;

  mmp_lane_t     head_q;
  mmp_lane_t     chain [VW+1];
  logic [VW:0]   chain_v;
  logic [VW-1:0] acc_q, acc_d;
  logic          sum_v_q;

  // Reduce the multiplicand once; loaded entries may sit above the prime.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else begin
      head_q.v     <= valid_i;
      head_q.first <= first_i;
      head_q.last  <= last_i;
      head_q.r     <= '0;
      head_q.a     <= (x_i >= PRIME) ? x_i - PRIME : x_i;
      head_q.b     <= y_i;
    end
  end

  assign chain[0] = head_q;

  for (genvar g = 0; g < VW; g++) begin : g_cell
    mmp_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .lane_i (chain[g]),
      .lane_o (chain[g+1])
    );
  end

  for (genvar g = 0; g <= VW; g++) begin : g_v
    assign chain_v[g] = chain[g].v;
  end

  always_comb begin
    acc_d = acc_q;
    if (chain[VW].v) begin
      acc_d = mod_add(chain[VW].first ? '0 : acc_q, chain[VW].r);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      sum_v_q <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      sum_v_q <= chain[VW].v & chain[VW].last;
    end
  end

  assign busy_o      = (|chain_v) | sum_v_q;
  assign sum_valid_o = sum_v_q;
  assign sum_o       = acc_q;

endmodule
`default_nettype wire

// ----- hdl/modular_matrix_power.sv -----
// Matrix power modulo 1000000007 by square-and-multiply; top level with the
// sequencer and the base, result and scratch memories. Depends on mmp_pkg, mmp_mac.
//
// A start item keeps busy high through the identity fill, then for each matrix
// product through the issue of one term per cycle into a 30-cell multiplier
// chain, the drain and the copy back, with one squaring per exponent bit up to
// the highest set bit plus one multiply per set bit, and finally through n*n
// result transfers on consecutive cycles. The single shared multiply chain
// carries every term. Results come one per cycle with res_valid_o and cannot
// be held off; the final transfer may appear in the first cycle that busy is low.
`timescale 1ns / 1ps
`default_nettype none
module modular_matrix_power #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  mmp_pkg::mmp_in_t  cmd_i,
  input  logic              cfg_we_i,
  input  logic [3:0]        cfg_wdata_i,
  output logic              res_valid_o,
  output mmp_pkg::mmp_out_t res_o
);
  import mmp_pkg::*;

  localparam int unsigned Depth = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_COPY  = 3'd5;
  localparam logic [2:0] S_STEP  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  function automatic logic [AW-1:0] addr_of(logic [2:0] r, logic [2:0] c);
    return AW'(int'(r) * MAX_DIM + int'(c));
  endfunction

  logic [VW-1:0] base_mem   [Depth];
  logic [VW-1:0] result_mem [Depth];
  logic [VW-1:0] scratch_mem[Depth];

  logic [2:0]  state_q, state_d;
  logic [3:0]  size_q, n_q, n_d;
  logic [31:0] exp_q, exp_d;
  logic        sq_q, sq_d;
  logic [2:0]  i_q, i_d, j_q, j_d, k_q, k_d;
  logic [2:0]  wi_q, wj_q;
  logic [2:0]  nm1;
  logic        i_end, j_end, k_end;

  logic          iss_v_q, iss_first_q, iss_last_q;
  logic [AW-1:0] ra_x, ra_y;
  logic [VW-1:0] bx_q, by_q, ry_q, sc_q;

  logic          cp_v_q;
  logic [AW-1:0] cp_addr_q;
  logic          o_v_q, o_last_q;
  logic [2:0]    o_row_q, o_col_q;

  logic          mac_busy, mac_sum_v;
  logic [VW-1:0] mac_sum;

  logic accept;

  assign accept = start & ~busy;
  assign busy   = (state_q != S_IDLE);
  assign nm1    = 3'(n_q - 4'd1);
  assign i_end  = (i_q == nm1);
  assign j_end  = (j_q == nm1);
  assign k_end  = (k_q == nm1);

  always_comb begin
    n_d = size_q;
    if (size_q == 4'd0) begin
      n_d = 4'd1;
    end else if (int'(size_q) > MAX_DIM) begin
      n_d = 4'(MAX_DIM);
    end
  end

  always_comb begin
    state_d = state_q;
    exp_d   = exp_q;
    sq_d    = sq_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && cmd_i.operation == OP_START) begin
          state_d = S_INIT;
          exp_d   = cmd_i.exponent;
          i_d     = '0;
          j_d     = '0;
        end
      end
      S_INIT, S_COPY, S_OUT: begin
        j_d = j_end ? '0 : j_q + 3'd1;
        if (j_end) begin
          i_d = i_q + 3'd1;
        end
        if (i_end && j_end) begin
          i_d = '0;
          unique case (state_q)
            S_INIT:  state_d = S_CHECK;
            S_COPY:  state_d = S_STEP;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_CHECK: begin
        i_d = '0;
        j_d = '0;
        k_d = '0;
        if (exp_q == '0) begin
          state_d = S_OUT;
        end else begin
          sq_d    = ~exp_q[0];
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        k_d = k_end ? '0 : k_q + 3'd1;
        if (k_end) begin
          j_d = j_end ? '0 : j_q + 3'd1;
          if (j_end) begin
            i_d = i_q + 3'd1;
          end
          if (i_end && j_end) begin
            i_d     = '0;
            state_d = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (!iss_v_q && !mac_busy) begin
          state_d = S_COPY;
        end
      end
      S_STEP: begin
        // After the multiply go straight on to the square of the same bit.
        if (sq_q) begin
          exp_d   = exp_q >> 1;
          state_d = S_CHECK;
        end else begin
          sq_d    = 1'b1;
          state_d = S_MUL;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      size_q  <= 4'd8;
      n_q     <= 4'd1;
      exp_q   <= '0;
      sq_q    <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      wi_q    <= '0;
      wj_q    <= '0;
      iss_v_q <= 1'b0;
      cp_v_q  <= 1'b0;
      o_v_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      exp_q   <= exp_d;
      sq_q    <= sq_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      if (accept && cmd_i.operation == OP_START) begin
        n_q <= n_d;
      end
      // Scratch write pointer follows the finished dot products.
      if (state_q == S_CHECK || state_q == S_STEP) begin
        wi_q <= '0;
        wj_q <= '0;
      end else if (mac_sum_v) begin
        wj_q <= (wj_q == nm1) ? '0 : wj_q + 3'd1;
        if (wj_q == nm1) begin
          wi_q <= wi_q + 3'd1;
        end
      end
      iss_v_q <= (state_q == S_MUL);
      cp_v_q  <= (state_q == S_COPY);
      o_v_q   <= (state_q == S_OUT);
    end
  end

  always_ff @(posedge clk_i) begin
    iss_first_q <= (k_q == '0);
    iss_last_q  <= k_end;
    cp_addr_q   <= addr_of(i_q, j_q);
    o_row_q     <= i_q;
    o_col_q     <= j_q;
    o_last_q    <= i_end & j_end;
  end

  assign ra_x = addr_of(i_q, k_q);
  assign ra_y = (state_q == S_OUT) ? addr_of(i_q, j_q) : addr_of(k_q, j_q);

  // Base memory: load or copy-back write, two reads for squaring.
  always_ff @(posedge clk_i) begin
    if (accept && cmd_i.operation == OP_LOAD &&
        int'(cmd_i.entry_row) < MAX_DIM && int'(cmd_i.entry_col) < MAX_DIM) begin
      base_mem[addr_of(cmd_i.entry_row, cmd_i.entry_col)] <= cmd_i.entry_value;
    end else if (cp_v_q && sq_q) begin
      base_mem[cp_addr_q] <= sc_q;
    end
    bx_q <= base_mem[ra_x];
    by_q <= base_mem[ra_y];
  end

  // Result memory: identity fill or copy-back write.
  always_ff @(posedge clk_i) begin
    if (state_q == S_INIT) begin
      result_mem[addr_of(i_q, j_q)] <= (i_q == j_q) ? VW'(1) : '0;
    end else if (cp_v_q && !sq_q) begin
      result_mem[cp_addr_q] <= sc_q;
    end
    ry_q <= result_mem[ra_y];
  end

  always_ff @(posedge clk_i) begin
    if (mac_sum_v) begin
      scratch_mem[addr_of(wi_q, wj_q)] <= mac_sum;
    end
    sc_q <= scratch_mem[addr_of(i_q, j_q)];
  end

  mmp_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (iss_v_q),
    .first_i     (iss_first_q),
    .last_i      (iss_last_q),
    .x_i         (bx_q),
    .y_i         (sq_q ? by_q : ry_q),
    .busy_o      (mac_busy),
    .sum_valid_o (mac_sum_v),
    .sum_o       (mac_sum)
  );

  assign res_valid_o     = o_v_q;
  assign res_o.out_row   = o_row_q;
  assign res_o.out_col   = o_col_q;
  assign res_o.out_value = ry_q;
  assign res_o.last      = o_last_q;

  a_out_from_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(state_q) == S_OUT)
    else $error("result transfer outside the output sweep");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |=> !res_valid_o)
    else $error("transfer after the final entry");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd_i.operation == OP_START |=> busy)
    else $error("start taken without going busy");

  a_no_mac_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_sum_v |-> state_q == S_MUL || state_q == S_DRAIN)
    else $error("dot product finished outside a matrix product");

endmodule
`default_nettype wire
